// File: hw/rtl/pkc_pkg.sv
// ----------------------------------------------------------------------------
// pkc_pkg: constants for the permutation keystream cipher
// Block size, key width and the fixed permutation and pad tables.
// ----------------------------------------------------------------------------
package pkc_pkg;

    localparam int BLOCK_SIZE = 64;
    localparam int IDX_W      = $clog2(BLOCK_SIZE);
    localparam int KEY_BITS   = 256;
    localparam int BIT_W      = $clog2(KEY_BITS);
    localparam int WORD_W     = 64;
    localparam int CFG_IDX_W  = 2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [7:0]       byte_t;

    localparam idx_t MIX_INIT [BLOCK_SIZE] = '{
        6'd50, 6'd57, 6'd14, 6'd8,  6'd53, 6'd6,  6'd19, 6'd47, 6'd12, 6'd60, 6'd7,
        6'd49, 6'd51, 6'd44, 6'd4,  6'd16, 6'd10, 6'd15, 6'd28, 6'd2,  6'd41, 6'd33,
        6'd35, 6'd42, 6'd23, 6'd21, 6'd38, 6'd29, 6'd27, 6'd36, 6'd63, 6'd48, 6'd59,
        6'd17, 6'd3,  6'd24, 6'd58, 6'd39, 6'd18, 6'd9,  6'd5,  6'd11, 6'd22, 6'd46,
        6'd45, 6'd40, 6'd1,  6'd34, 6'd32, 6'd56, 6'd43, 6'd61, 6'd37, 6'd31, 6'd30,
        6'd13, 6'd20, 6'd55, 6'd0,  6'd62, 6'd26, 6'd25, 6'd52, 6'd54};

    localparam idx_t TABLE_ZERO [BLOCK_SIZE] = '{
        6'd13, 6'd10, 6'd0,  6'd27, 6'd1,  6'd35, 6'd50, 6'd39, 6'd53, 6'd21, 6'd36,
        6'd25, 6'd20, 6'd49, 6'd24, 6'd3,  6'd54, 6'd38, 6'd42, 6'd45, 6'd26, 6'd7,
        6'd17, 6'd2,  6'd60, 6'd56, 6'd30, 6'd4,  6'd34, 6'd58, 6'd5,  6'd16, 6'd12,
        6'd23, 6'd46, 6'd19, 6'd31, 6'd9,  6'd41, 6'd37, 6'd43, 6'd57, 6'd52, 6'd33,
        6'd28, 6'd48, 6'd63, 6'd11, 6'd61, 6'd51, 6'd29, 6'd32, 6'd40, 6'd15, 6'd18,
        6'd8,  6'd6,  6'd22, 6'd44, 6'd62, 6'd14, 6'd55, 6'd47, 6'd59};

    localparam idx_t TABLE_ONE [BLOCK_SIZE] = '{
        6'd26, 6'd31, 6'd29, 6'd50, 6'd1,  6'd54, 6'd0,  6'd7,  6'd42, 6'd9,  6'd19,
        6'd35, 6'd24, 6'd53, 6'd63, 6'd15, 6'd59, 6'd30, 6'd44, 6'd60, 6'd36, 6'd56,
        6'd37, 6'd22, 6'd57, 6'd20, 6'd61, 6'd23, 6'd12, 6'd40, 6'd10, 6'd14, 6'd6,
        6'd33, 6'd58, 6'd55, 6'd4,  6'd21, 6'd38, 6'd16, 6'd32, 6'd17, 6'd18, 6'd3,
        6'd46, 6'd8,  6'd25, 6'd52, 6'd43, 6'd5,  6'd48, 6'd51, 6'd45, 6'd39, 6'd2,
        6'd49, 6'd41, 6'd47, 6'd11, 6'd27, 6'd34, 6'd13, 6'd62, 6'd28};

    localparam byte_t PAD_INIT [BLOCK_SIZE] = '{
        8'd148, 8'd246, 8'd52,  8'd251, 8'd16,  8'd194, 8'd72,  8'd150, 8'd249, 8'd23,
        8'd90,  8'd107, 8'd151, 8'd42,  8'd154, 8'd124, 8'd48,  8'd58,  8'd30,  8'd24,
        8'd42,  8'd33,  8'd38,  8'd10,  8'd115, 8'd41,  8'd164, 8'd16,  8'd33,  8'd32,
        8'd252, 8'd143, 8'd86,  8'd175, 8'd8,   8'd132, 8'd103, 8'd231, 8'd95,  8'd190,
        8'd61,  8'd29,  8'd215, 8'd75,  8'd251, 8'd248, 8'd72,  8'd48,  8'd224, 8'd200,
        8'd147, 8'd93,  8'd112, 8'd25,  8'd227, 8'd223, 8'd206, 8'd137, 8'd51,  8'd88,
        8'd109, 8'd214, 8'd17,  8'd172};

endpackage

// File: hw/rtl/permutation_keystream_cipher.sv
// ----------------------------------------------------------------------------
// permutation_keystream_cipher
// Byte-stream XOR cipher with a keystream from 64-entry permutations.
// ----------------------------------------------------------------------------
// Input beats carry data_byte and first_byte; output beats carry out_byte.
// Both channels use valid and stall. The key words are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while the
// block is idle; the block itself does not enforce this. A byte inside a
// 64-byte block passes through S_OA and S_OB and raises out_valid once the
// output register is loaded; the block then returns to idle for the next byte.
// The first byte of each block first runs the block refresh through the
// permutation and pad memories: a conjugation pass in S_RA to S_RD, a copy
// pass in S_CA and S_CB and a pad update in S_PA to S_PD, over all 64 entries.
// A byte with first_byte set first runs the key schedule, 64 entries of 256
// table steps each through one table lookup unit, then the refresh.
// The block takes one byte at a time; in_stall is high while it works.
// A finished result waits in the output register while out_stall is high,
// and the next input beat is still taken meanwhile.
// Reset clears the key words and restores the identity key permutation, the
// fixed mixing table and the fixed pad; no clearing pass is needed.
// ----------------------------------------------------------------------------
module permutation_keystream_cipher (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pkc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pkc_pkg::WORD_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        data_byte,
    input  logic                              first_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        out_byte
);
    import pkc_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_KEY  = 14'b00000000000010,
        S_RA   = 14'b00000000000100,
        S_RB   = 14'b00000000001000,
        S_RC   = 14'b00000000010000,
        S_RD   = 14'b00000000100000,
        S_CA   = 14'b00000001000000,
        S_CB   = 14'b00000010000000,
        S_PA   = 14'b00000100000000,
        S_PB   = 14'b00001000000000,
        S_PC   = 14'b00010000000000,
        S_PD   = 14'b00100000000000,
        S_OA   = 14'b01000000000000,
        S_OB   = 14'b10000000000000
    } state_t;

    localparam idx_t IDX_LAST = idx_t'(BLOCK_SIZE - 1);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(KEY_BITS - 1);

    state_t state_reg, state_next;
    logic [WORD_W-1:0] key_word_reg [4];
    logic [KEY_BITS-1:0] key_all;
    idx_t idx_reg, idx_next;
    idx_t pos_reg, pos_next;
    idx_t kx_reg, kx_next, kx_step;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic key_loaded_reg, key_loaded_next;
    logic [BLOCK_SIZE-1:0] mix_vld_reg, mix_vld_next;
    logic [BLOCK_SIZE-1:0] pad_vld_reg, pad_vld_next;
    byte_t data_reg;
    byte_t tmp_reg;
    logic out_valid_reg, out_valid_next;
    byte_t out_byte_reg;
    logic in_fire, load_out;

    idx_t kp_mem   [BLOCK_SIZE];
    idx_t kinv_mem [BLOCK_SIZE];
    idx_t mix_mem  [BLOCK_SIZE];
    idx_t scr_mem  [BLOCK_SIZE];
    byte_t pad_mem [BLOCK_SIZE];

    idx_t kp_raddr, kinv_raddr, mix_raddr, scr_raddr, pad_raddr;
    idx_t kp_addr_q, kinv_addr_q, mix_addr_q, pad_addr_q;
    idx_t kp_q, kinv_q, mix_q, scr_q;
    byte_t pad_q;
    idx_t kp_val, kinv_val, mix_val;
    byte_t pad_val;
    logic kp_we, mix_we, scr_we, pad_we;
    idx_t mix_wdata;
    byte_t pad_wdata;

    assign key_all  = {key_word_reg[3], key_word_reg[2], key_word_reg[1], key_word_reg[0]};
    assign kx_step  = key_all[bit_reg] ? TABLE_ONE[kx_reg] : TABLE_ZERO[kx_reg];
    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign load_out = (state_reg == S_OB) && !(out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    assign kp_val   = key_loaded_reg ? kp_q : kp_addr_q;
    assign kinv_val = key_loaded_reg ? kinv_q : kinv_addr_q;
    assign mix_val  = mix_vld_reg[mix_addr_q] ? mix_q : MIX_INIT[mix_addr_q];
    assign pad_val  = pad_vld_reg[pad_addr_q] ? pad_q : PAD_INIT[pad_addr_q];

    always_comb
    begin
        kp_raddr   = idx_reg;
        kinv_raddr = idx_reg;
        mix_raddr  = idx_reg;
        scr_raddr  = idx_reg;
        pad_raddr  = idx_reg;
        kp_we      = 1'b0;
        mix_we     = 1'b0;
        scr_we     = 1'b0;
        pad_we     = 1'b0;
        mix_wdata  = scr_q;
        pad_wdata  = pad_val ^ tmp_reg;
        case (state_reg)
            S_KEY:   kp_we = (bit_reg == '0);
            S_RB:    mix_raddr = kinv_val;
            S_RC:    kp_raddr = mix_val;
            S_RD:    scr_we = 1'b1;
            S_CB:    mix_we = 1'b1;
            S_PB:    pad_raddr = mix_val;
            S_PD:    pad_we = 1'b1;
            S_OA:    pad_raddr = pos_reg;
            S_OB:    pad_raddr = pos_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (kp_we)
        begin
            kp_mem[idx_reg]   <= kx_step;
            kinv_mem[kx_step] <= idx_reg;
        end
        if (scr_we)
            scr_mem[idx_reg] <= kp_val;
        if (mix_we)
            mix_mem[idx_reg] <= mix_wdata;
        if (pad_we)
            pad_mem[idx_reg] <= pad_wdata;
        kp_q        <= kp_mem[kp_raddr];
        kinv_q      <= kinv_mem[kinv_raddr];
        mix_q       <= mix_mem[mix_raddr];
        scr_q       <= scr_mem[scr_raddr];
        pad_q       <= pad_mem[pad_raddr];
        kp_addr_q   <= kp_raddr;
        kinv_addr_q <= kinv_raddr;
        mix_addr_q  <= mix_raddr;
        pad_addr_q  <= pad_raddr;
        if (in_fire)
            data_reg <= data_byte;
        if (state_reg == S_PC)
            tmp_reg <= pad_val;
        if (load_out)
            out_byte_reg <= data_reg ^ pad_val;
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        kx_next         = kx_reg;
        bit_next        = bit_reg;
        key_loaded_next = key_loaded_reg;
        mix_vld_next    = mix_vld_reg;
        pad_vld_next    = pad_vld_reg;
        out_valid_next  = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    idx_next = '0;
                    if (first_byte)
                    begin
                        mix_vld_next = '0;
                        pad_vld_next = '0;
                        pos_next     = '0;
                        kx_next      = '0;
                        bit_next     = BIT_LAST;
                        state_next   = S_KEY;
                    end
                    else if (pos_reg == '0)
                        state_next = S_RA;
                    else
                        state_next = S_OA;
                end
            end
            S_KEY:
            begin
                kx_next  = kx_step;
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    kx_next  = idx_reg + 1'b1;
                    bit_next = BIT_LAST;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == IDX_LAST)
                    begin
                        key_loaded_next = 1'b1;
                        state_next      = S_RA;
                    end
                end
            end
            S_RA: state_next = S_RB;
            S_RB: state_next = S_RC;
            S_RC: state_next = S_RD;
            S_RD:
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg == IDX_LAST) ? S_CA : S_RA;
            end
            S_CA: state_next = S_CB;
            S_CB:
            begin
                mix_vld_next[idx_reg] = 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg == IDX_LAST) ? S_PA : S_CA;
            end
            S_PA: state_next = S_PB;
            S_PB: state_next = S_PC;
            S_PC: state_next = S_PD;
            S_PD:
            begin
                pad_vld_next[idx_reg] = 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg == IDX_LAST) ? S_OA : S_PA;
            end
            S_OA: state_next = S_OB;
            S_OB:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    pos_next       = pos_reg + 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            pos_reg         <= '0;
            kx_reg          <= '0;
            bit_reg         <= '0;
            key_loaded_reg  <= 1'b0;
            mix_vld_reg     <= '0;
            pad_vld_reg     <= '0;
            out_valid_reg   <= 1'b0;
            key_word_reg[0] <= '0;
            key_word_reg[1] <= '0;
            key_word_reg[2] <= '0;
            key_word_reg[3] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pos_reg        <= pos_next;
            kx_reg         <= kx_next;
            bit_reg        <= bit_next;
            key_loaded_reg <= key_loaded_next;
            mix_vld_reg    <= mix_vld_next;
            pad_vld_reg    <= pad_vld_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
                key_word_reg[cfg_index] <= cfg_data;
        end
    end

    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (pos_reg == idx_t'($past(pos_reg) + 1'b1)))
        else $error("byte position did not advance with an output beat");

    a_key_from_schedule: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(key_loaded_reg) |-> $past(state_reg == S_KEY))
        else $error("key permutation marked loaded outside the key schedule");

    a_refresh_at_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RA) |-> (pos_reg == '0))
        else $error("block refresh started away from a block boundary");

endmodule
